// ===== hw/rtl/pwlcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlcm_pkg
// Shared types, constants and helpers of the piecewise-linear color map.
// ----------------------------------------------------------------------------

package pwlcm_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_STOPS_DEF     = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // Bits of the alpha quotient (alpha runs 0..255).
  localparam int ALPHA_BITS = 8;

  // Packed stop table: eight 24-bit RGB stops.
  localparam int STOP_W       = 24;
  localparam int STOP_SLOTS   = 8;
  localparam int STOP_TABLE_W = STOP_W * STOP_SLOTS;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_COLOR_LOW  = 3'd0,
    REG_COLOR_HIGH = 3'd1,
    REG_ALPHA_LOW  = 3'd2,
    REG_ALPHA_HIGH = 3'd3,
    REG_STOP_COUNT = 3'd4,
    REG_STOPS_LOW  = 3'd5,
    REG_STOPS_MID  = 3'd6,
    REG_STOPS_HIGH = 3'd7
  } reg_index_t;

  // Where a ratio falls: at or below zero, strictly inside, at or above one.
  typedef enum logic [1:0] {
    WHERE_LOW  = 2'd0,
    WHERE_MID  = 2'd1,
    WHERE_HIGH = 2'd2
  } where_t;

  // Register file contents seen by the datapath.
  typedef struct packed {
    logic signed [31:0]        color_low;
    logic signed [31:0]        color_high;
    logic signed [31:0]        alpha_low;
    logic signed [31:0]        alpha_high;
    logic [3:0]                stop_count;
    logic [STOP_TABLE_W-1:0]   stops;
  } cfg_t;

  // Per-item control that travels alongside the divider data.
  typedef struct packed {
    where_t      cwhere;
    where_t      awhere;
    logic        white;
    logic        aopaque;
    logic [31:0] cden;
    logic [31:0] aden;
  } prep_t;

  // RGB of stop k from the packed table: red 23:16, green 15:8, blue 7:0.
  function automatic logic [STOP_W-1:0] stop_rgb(input logic [STOP_TABLE_W-1:0] tbl,
                                                 input logic [2:0] k);
    return tbl[STOP_W * k +: STOP_W];
  endfunction

endpackage

// ===== hw/rtl/pwlcm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlcm_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------

module pwlcm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwlcm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pwlcm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pwlcm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output pwlcm_pkg::cfg_t                     cfg
);

  logic signed [31:0] color_low;
  logic signed [31:0] color_high;
  logic signed [31:0] alpha_low;
  logic signed [31:0] alpha_high;
  logic [3:0]         stop_count;
  logic [63:0]        stops_low;
  logic [63:0]        stops_mid;
  logic [63:0]        stops_high;
  logic               wr;
  pwlcm_pkg::reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = pwlcm_pkg::reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      color_low  <= '0;
      color_high <= '0;
      alpha_low  <= '0;
      alpha_high <= '0;
      stop_count <= 4'd3;
      stops_low  <= 64'h0000_FFFF_0000_FF00;
      stops_mid  <= 64'h0000_0000_0000_00FF;
      stops_high <= '0;
    end else if (wr) begin
      case (idx)
        pwlcm_pkg::REG_COLOR_LOW:  color_low  <= pwdata[31:0];
        pwlcm_pkg::REG_COLOR_HIGH: color_high <= pwdata[31:0];
        pwlcm_pkg::REG_ALPHA_LOW:  alpha_low  <= pwdata[31:0];
        pwlcm_pkg::REG_ALPHA_HIGH: alpha_high <= pwdata[31:0];
        pwlcm_pkg::REG_STOP_COUNT: stop_count <= pwdata[3:0];
        pwlcm_pkg::REG_STOPS_LOW:  stops_low  <= pwdata;
        pwlcm_pkg::REG_STOPS_MID:  stops_mid  <= pwdata;
        pwlcm_pkg::REG_STOPS_HIGH: stops_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwlcm_pkg::REG_COLOR_LOW:  prdata = {32'd0, color_low};
      pwlcm_pkg::REG_COLOR_HIGH: prdata = {32'd0, color_high};
      pwlcm_pkg::REG_ALPHA_LOW:  prdata = {32'd0, alpha_low};
      pwlcm_pkg::REG_ALPHA_HIGH: prdata = {32'd0, alpha_high};
      pwlcm_pkg::REG_STOP_COUNT: prdata = {60'd0, stop_count};
      pwlcm_pkg::REG_STOPS_LOW:  prdata = stops_low;
      pwlcm_pkg::REG_STOPS_MID:  prdata = stops_mid;
      pwlcm_pkg::REG_STOPS_HIGH: prdata = stops_high;
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.color_low  = color_low;
    cfg.color_high = color_high;
    cfg.alpha_low  = alpha_low;
    cfg.alpha_high = alpha_high;
    cfg.stop_count = stop_count;
    cfg.stops      = {stops_high, stops_mid, stops_low};
  end

endmodule

// ===== hw/rtl/pwlcm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlcm_front
// Three stages: offsets from the bounds, sign normalization, classification
// and divider seeding for the color and alpha ratios.
// ----------------------------------------------------------------------------

module pwlcm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  pwlcm_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  input  logic signed [31:0]   sample_value,
  output logic                 out_valid,
  output pwlcm_pkg::prep_t     info,
  output logic [31:0]          crem,
  output logic [39:0]          arem
);

  logic               v1, v2, v3;
  logic signed [32:0] cnum1, cden1, anum1, aden1;
  logic               white1, aop1;
  logic signed [32:0] cnum2, cden2, anum2, aden2;
  logic               white2, aop2;
  logic [39:0]        anum_wide;

  function automatic pwlcm_pkg::where_t where_of(input logic signed [32:0] num,
                                                 input logic signed [32:0] den);
    if (num <= 33'sd0) begin
      return pwlcm_pkg::WHERE_LOW;
    end else if (den == 33'sd0 || num >= den) begin
      return pwlcm_pkg::WHERE_HIGH;
    end
    return pwlcm_pkg::WHERE_MID;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign anum_wide = {8'd0, anum2[31:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      // Offsets from the low bound, 33 bits so nothing wraps.
      cnum1  <= 33'(sample_value) - 33'(cfg.color_low);
      cden1  <= 33'(cfg.color_high) - 33'(cfg.color_low);
      anum1  <= 33'(sample_value) - 33'(cfg.alpha_low);
      aden1  <= 33'(cfg.alpha_high) - 33'(cfg.alpha_low);
      white1 <= (cfg.color_low == 32'sd0 && cfg.color_high == 32'sd0) ||
                (cfg.stop_count == 4'd0);
      aop1   <= (cfg.alpha_low == 32'sd0 && cfg.alpha_high == 32'sd0);

      // Make the denominator non-negative.
      cnum2  <= (cden1 < 33'sd0) ? -cnum1 : cnum1;
      cden2  <= (cden1 < 33'sd0) ? -cden1 : cden1;
      anum2  <= (aden1 < 33'sd0) ? -anum1 : anum1;
      aden2  <= (aden1 < 33'sd0) ? -aden1 : aden1;
      white2 <= white1;
      aop2   <= aop1;

      // Strictly inside, 0 < num < den, so both fit 32 bits unsigned.
      info.cwhere  <= where_of(cnum2, cden2);
      info.awhere  <= where_of(anum2, aden2);
      info.white   <= white2;
      info.aopaque <= aop2;
      info.cden    <= cden2[31:0];
      info.aden    <= aden2[31:0];
      crem         <= cnum2[31:0];
      arem         <= (anum_wide << 8) - anum_wide;
    end
  end

  assign out_valid = v3;

endmodule

// ===== hw/rtl/pwlcm_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlcm_div_stage
// One restoring-division step for the color fraction and, in the first
// stages, one step of the alpha quotient.
// ----------------------------------------------------------------------------

module pwlcm_div_stage #(
  parameter int FRACTION_BITS = pwlcm_pkg::FRACTION_BITS_DEF,
  parameter int STEP          = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  pwlcm_pkg::prep_t          in_info,
  input  logic [31:0]               in_crem,
  input  logic [FRACTION_BITS-1:0]  in_cq,
  input  logic [39:0]               in_arem,
  input  logic [pwlcm_pkg::ALPHA_BITS-1:0] in_aq,
  output logic                      out_valid,
  output pwlcm_pkg::prep_t          out_info,
  output logic [31:0]               out_crem,
  output logic [FRACTION_BITS-1:0]  out_cq,
  output logic [39:0]               out_arem,
  output logic [pwlcm_pkg::ALPHA_BITS-1:0] out_aq
);

  logic [32:0] shifted;
  logic        cbit;

  assign shifted = {in_crem, 1'b0};
  assign cbit    = shifted >= {1'b0, in_info.cden};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Without a quotient bit the doubled remainder stays below the divisor,
  // so it fits in 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      out_info <= in_info;
      out_crem <= cbit ? 32'(shifted - {1'b0, in_info.cden}) : shifted[31:0];
      out_cq   <= {in_cq[FRACTION_BITS-2:0], cbit};
    end
  end

  generate
    if (STEP < pwlcm_pkg::ALPHA_BITS) begin : g_alpha
      localparam int SHIFT = pwlcm_pkg::ALPHA_BITS - 1 - STEP;
      logic [39:0] dsh;
      logic        abit;

      assign dsh  = {8'd0, in_info.aden} << SHIFT;
      assign abit = in_arem >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          out_arem <= abit ? in_arem - dsh : in_arem;
          out_aq   <= {in_aq[pwlcm_pkg::ALPHA_BITS-2:0], abit};
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          out_arem <= in_arem;
          out_aq   <= in_aq;
        end
      end
    end
  endgenerate

endmodule

// ===== hw/rtl/pwlcm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlcm_back
// Three stages: segment selection, stop fetch, per-channel blend into the
// output register.
// ----------------------------------------------------------------------------

module pwlcm_back #(
  parameter int MAX_STOPS     = pwlcm_pkg::MAX_STOPS_DEF,
  parameter int FRACTION_BITS = pwlcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  pwlcm_pkg::cfg_t           cfg,
  input  logic                      in_valid,
  input  pwlcm_pkg::prep_t          info,
  input  logic [FRACTION_BITS-1:0]  cq,
  input  logic [pwlcm_pkg::ALPHA_BITS-1:0] aq,
  output logic                      out_valid,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic [7:0]                alpha
);

  localparam int            SC_W  = FRACTION_BITS + 3;
  localparam int            LW    = FRACTION_BITS + 10;
  localparam logic [3:0]    MAX_N = 4'(MAX_STOPS);

  logic                     v1, v2;
  logic [3:0]               n;
  logic [2:0]               nm1;
  logic [SC_W-1:0]          scaled;
  logic [2:0]               seg;
  logic [3:0]               seg_up;
  logic [2:0]               i0_next, i1_next;
  logic [FRACTION_BITS-1:0] t_next;
  logic [7:0]               alpha_next;

  logic [2:0]               i0, i1;
  logic [FRACTION_BITS-1:0] t1, t2;
  logic                     white1, white2;
  logic [7:0]               alpha1, alpha2;
  logic [pwlcm_pkg::STOP_W-1:0] c0, c1;

  function automatic logic [7:0] blend(input logic [7:0] ca, input logic [7:0] cb,
                                       input logic [FRACTION_BITS-1:0] t);
    logic [LW-1:0] one_m_t;
    logic [LW-1:0] acc;
    one_m_t = (LW'(1) << FRACTION_BITS) - LW'(t);
    acc     = LW'(ca) * one_m_t + LW'(cb) * LW'(t);
    return acc[FRACTION_BITS +: 8];
  endfunction

  assign n      = (cfg.stop_count > MAX_N) ? MAX_N : cfg.stop_count;
  assign nm1    = n[2:0] - 3'd1;
  assign scaled = SC_W'(cq) * SC_W'(nm1);
  assign seg    = (scaled[FRACTION_BITS +: 3] >= nm1) ? nm1 : scaled[FRACTION_BITS +: 3];
  assign seg_up = {1'b0, seg} + 4'd1;

  always_comb begin
    case (info.cwhere)
      pwlcm_pkg::WHERE_MID: begin
        i0_next = seg;
        i1_next = (seg_up < n) ? seg_up[2:0] : seg;
        t_next  = scaled[FRACTION_BITS-1:0];
      end
      pwlcm_pkg::WHERE_HIGH: begin
        i0_next = nm1;
        i1_next = nm1;
        t_next  = '0;
      end
      default: begin
        i0_next = 3'd0;
        i1_next = 3'd0;
        t_next  = '0;
      end
    endcase

    if (info.aopaque) begin
      alpha_next = 8'hFF;
    end else begin
      case (info.awhere)
        pwlcm_pkg::WHERE_MID:  alpha_next = aq;
        pwlcm_pkg::WHERE_HIGH: alpha_next = 8'hFF;
        default:               alpha_next = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i0     <= i0_next;
      i1     <= i1_next;
      t1     <= t_next;
      white1 <= info.white;
      alpha1 <= alpha_next;

      c0     <= pwlcm_pkg::stop_rgb(cfg.stops, i0);
      c1     <= pwlcm_pkg::stop_rgb(cfg.stops, i1);
      t2     <= t1;
      white2 <= white1;
      alpha2 <= alpha1;

      red    <= white2 ? 8'hFF : blend(c0[23:16], c1[23:16], t2);
      green  <= white2 ? 8'hFF : blend(c0[15:8],  c1[15:8],  t2);
      blue   <= white2 ? 8'hFF : blend(c0[7:0],   c1[7:0],   t2);
      alpha  <= alpha2;
    end
  end

endmodule

// ===== hw/rtl/piecewise_linear_color_map_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_color_map_unit
// Maps a signed Q16.16 sample to an RGBA color through a piecewise-linear
// table of up to eight RGB stops, with a separate clamped alpha ramp.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Contents
// s_axis    in         s_tvalid / s_tready     sample_value, signed Q16.16
// m_axis    out        m_tvalid / m_tready     red, green, blue, alpha bytes
// apb       in         psel/penable/pready     eight 64-bit config registers
//
// Every item passes through three front stages, one stage per fraction
// bit of the restoring divider, and three back stages ending in the
// output register.
// A new item is taken in every cycle as long as the output is not stalled.
// A stall freezes every stage at once; s_tready drops in the same cycle.
// Reset clears all valid bits and loads the register defaults; the stop
// table comes up as green, yellow, red with three stops in use.
//
// The alpha quotient needs only eight division steps and rides in the first
// eight divider stages; the color fraction uses all of them. Configuration
// is read live by the front and back stages, so it should change only while
// the pipeline is empty.

module piecewise_linear_color_map_unit #(
  parameter int MAX_STOPS     = pwlcm_pkg::MAX_STOPS_DEF,
  parameter int FRACTION_BITS = pwlcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Sample input.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // [31:0] sample_value
  // Color output.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [31:24] alpha
  // Configuration.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pwlcm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pwlcm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pwlcm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int DEPTH = FRACTION_BITS;

  pwlcm_pkg::cfg_t cfg;
  logic            en;

  // Divider chain taps: index 0 is the front's output, DEPTH the last step.
  logic                     dv_valid [0:DEPTH];
  pwlcm_pkg::prep_t         dv_info  [0:DEPTH];
  logic [31:0]              dv_crem  [0:DEPTH];
  logic [FRACTION_BITS-1:0] dv_cq    [0:DEPTH];
  logic [39:0]              dv_arem  [0:DEPTH];
  logic [pwlcm_pkg::ALPHA_BITS-1:0] dv_aq [0:DEPTH];

  logic [7:0] red, green, blue, alpha;

  // The whole pipeline advances unless a finished item waits at the output.
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  pwlcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwlcm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .sample_value ($signed(s_tdata)),
    .out_valid    (dv_valid[0]),
    .info         (dv_info[0]),
    .crem         (dv_crem[0]),
    .arem         (dv_arem[0])
  );

  // Quotients are built by shifting in one bit per stage, alpha only in the first eight.
  assign dv_cq[0] = '0;
  assign dv_aq[0] = '0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_div
      pwlcm_div_stage #(
        .FRACTION_BITS (FRACTION_BITS),
        .STEP          (i)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (dv_valid[i]),
        .in_info   (dv_info[i]),
        .in_crem   (dv_crem[i]),
        .in_cq     (dv_cq[i]),
        .in_arem   (dv_arem[i]),
        .in_aq     (dv_aq[i]),
        .out_valid (dv_valid[i+1]),
        .out_info  (dv_info[i+1]),
        .out_crem  (dv_crem[i+1]),
        .out_cq    (dv_cq[i+1]),
        .out_arem  (dv_arem[i+1]),
        .out_aq    (dv_aq[i+1])
      );
    end
  endgenerate

  pwlcm_back #(
    .MAX_STOPS     (MAX_STOPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (dv_valid[DEPTH]),
    .info      (dv_info[DEPTH]),
    .cq        (dv_cq[DEPTH]),
    .aq        (dv_aq[DEPTH]),
    .out_valid (m_tvalid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha)
  );

  assign m_tdata = {alpha, blue, green, red};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for piecewise_linear_color_map_unit. Samples go in on
// the input stream and RGBA bytes come out on the output stream. A bit-exact
// model of the color ramp and the alpha ramp, kept inside the bench, predicts
// each result, and every result is checked field by field against the model.
// The register file is reprogrammed over APB between phases. The directed
// phases come first, then random phases, mostly with random backpressure.
// ----------------------------------------------------------------------------

module tb;

  localparam int FRAC_BITS  = pwlcm_pkg::FRACTION_BITS_DEF;
  localparam int STOP_LIMIT = pwlcm_pkg::MAX_STOPS_DEF;
  localparam int DRAIN_WAIT = 40;       // comfortably above the pipeline depth
  localparam int ITEMS_PER_PHASE = 117; // six random phases, about 700 items

  // Output item as it sits in m_tdata: red in the low byte, alpha on top.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [31:0]                      s_tdata = '0;   // [31:0] sample_value
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [31:0]                      m_tdata;        // [7:0] red, [15:8] green,
                                                    // [23:16] blue, [31:24] alpha
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [pwlcm_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pwlcm_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pwlcm_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  piecewise_linear_color_map_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Bench copy of the register file, starting from the reset values. It is
  // only updated by the register write task, so it always mirrors the block.
  int                                 color_low  = 0;
  int                                 color_high = 0;
  int                                 alpha_low  = 0;
  int                                 alpha_high = 0;
  logic [3:0]                         stop_count = 4'd3;
  logic [pwlcm_pkg::STOP_TABLE_W-1:0] stop_table = {64'h0, 64'hFF, 64'h0000_FFFF_0000_FF00};

  logic [31:0] pending_samples[$];   // samples waiting to be offered
  rgba_t       expected_colors[$];   // predicted colors, oldest first
  int          send_idle_pct = 0;    // chance per cycle that the sender holds off
  int          recv_idle_pct = 0;    // chance per cycle that the receiver stalls
  int          mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Color model
  // ---------------------------------------------------------------------------

  // Places num/den relative to [0,1]. Inside the interval the ratio is also
  // returned as a floored fraction num*scale/den. A zero denominator puts
  // every positive numerator at the top end.
  function automatic pwlcm_pkg::where_t ratio_place(input longint num, input longint den,
                                                    input longint unsigned scale,
                                                    output longint unsigned frac);
    frac = 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return pwlcm_pkg::WHERE_LOW;
    if (den == 0 || num >= den) return pwlcm_pkg::WHERE_HIGH;
    frac = ($unsigned(num) * scale) / $unsigned(den);
    return pwlcm_pkg::WHERE_MID;
  endfunction

  function automatic logic [pwlcm_pkg::STOP_W-1:0] stop_color(input int k);
    return stop_table[pwlcm_pkg::STOP_W * (k % pwlcm_pkg::STOP_SLOTS) +: pwlcm_pkg::STOP_W];
  endfunction

  // Floor of a*(1-t) + b*t with t in FRAC_BITS fractional bits.
  function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
                                               input longint unsigned t);
    longint unsigned ca, cb, one, acc;
    ca = a;
    cb = b;
    one = longint'(1) << FRAC_BITS;
    acc = (ca * (one - t) + cb * t) >> FRAC_BITS;
    return acc[7:0];
  endfunction

  function automatic rgba_t predict_color(input logic [31:0] sample);
    rgba_t                        c;
    int                           sv;
    longint                       v, n, seg;
    longint unsigned              frac, scaled, t;
    pwlcm_pkg::where_t            place;
    logic [pwlcm_pkg::STOP_W-1:0] c0, c1;
    sv = sample;
    v = sv;
    c = '1;
    n = (stop_count > STOP_LIMIT) ? STOP_LIMIT : stop_count;

    // White unless the color bounds are set and at least one stop is in use.
    if (!(color_low == 0 && color_high == 0) && n > 0) begin
      place = ratio_place(v - color_low, longint'(color_high) - color_low,
                          longint'(1) << FRAC_BITS, frac);
      if (place != pwlcm_pkg::WHERE_MID) begin
        c0 = stop_color(place == pwlcm_pkg::WHERE_LOW ? 0 : int'(n - 1));
        c.red   = c0[23:16];
        c.green = c0[15:8];
        c.blue  = c0[7:0];
      end else begin
        // The fraction picks a segment in its integer part and a blend weight
        // in its fractional part.
        scaled = frac * $unsigned(n - 1);
        seg = scaled >> FRAC_BITS;
        t = scaled & ((longint'(1) << FRAC_BITS) - 1);
        if (seg >= n - 1) seg = n - 1;
        c0 = stop_color(int'(seg));
        c1 = stop_color(seg + 1 < n ? int'(seg + 1) : int'(seg));
        c.red   = blend_channel(c0[23:16], c1[23:16], t);
        c.green = blend_channel(c0[15:8],  c1[15:8],  t);
        c.blue  = blend_channel(c0[7:0],   c1[7:0],   t);
      end
    end

    // Alpha is opaque when both alpha bounds are zero, else a clamped ramp.
    if (!(alpha_low == 0 && alpha_high == 0)) begin
      place = ratio_place(v - alpha_low, longint'(alpha_high) - alpha_low, 255, frac);
      case (place)
        pwlcm_pkg::WHERE_LOW:  c.alpha = 8'd0;
        pwlcm_pkg::WHERE_HIGH: c.alpha = 8'd255;
        default:               c.alpha = frac[7:0];
      endcase
    end
    return c;
  endfunction

  // Appends one sample to the queue of samples still to be offered.
  task automatic queue_sample(input logic [31:0] sample);
    pending_samples = {pending_samples, sample};
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  // One APB write: setup cycle, access cycle, then the bus goes idle. The
  // register takes the value at the edge that ends the access cycle, and
  // the bench copy follows it.
  task automatic program_register(input pwlcm_pkg::reg_index_t idx,
                                  input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pwlcm_pkg::REG_COLOR_LOW:  color_low  = value[31:0];
      pwlcm_pkg::REG_COLOR_HIGH: color_high = value[31:0];
      pwlcm_pkg::REG_ALPHA_LOW:  alpha_low  = value[31:0];
      pwlcm_pkg::REG_ALPHA_HIGH: alpha_high = value[31:0];
      pwlcm_pkg::REG_STOP_COUNT: stop_count = value[3:0];
      pwlcm_pkg::REG_STOPS_LOW:  stop_table[63:0]    = value;
      pwlcm_pkg::REG_STOPS_MID:  stop_table[127:64]  = value;
      pwlcm_pkg::REG_STOPS_HIGH: stop_table[191:128] = value;
      default: ;
    endcase
  endtask

  task automatic program_bounds(input int c_lo, input int c_hi,
                                input int a_lo, input int a_hi);
    program_register(pwlcm_pkg::REG_COLOR_LOW,  {32'h0, c_lo});
    program_register(pwlcm_pkg::REG_COLOR_HIGH, {32'h0, c_hi});
    program_register(pwlcm_pkg::REG_ALPHA_LOW,  {32'h0, a_lo});
    program_register(pwlcm_pkg::REG_ALPHA_HIGH, {32'h0, a_hi});
  endtask

  // The configuration is read live by the front and back stages, so a phase ends
  // only when every sample has been taken and every color has come back.
  task automatic wait_until_drained();
    while (pending_samples.size() != 0 || s_tvalid || expected_colors.size() != 0)
      @(posedge clk);
  endtask

  // A pair of bounds for one ramp. Half the pairs are a narrow window somewhere in
  // the full range, in either order, so that many samples land inside it; the
  // rest are fully random, equal, zero or the widest possible pair.
  task automatic pick_bound_pair(output int lo, output int hi);
    longint wide;
    int     span;
    lo = $urandom;
    case ($urandom_range(0, 7))
      0: hi = $urandom;
      1: hi = lo;
      2: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      3: begin
        lo = 0;
        hi = 0;
      end
      default: begin
        span = $urandom_range(1, 1 << 20);
        wide = longint'(lo) + (($urandom_range(0, 3) == 0) ? -span : span);
        if (wide > 64'sh7FFF_FFFF) wide = 64'sh7FFF_FFFF;
        if (wide < -64'sh8000_0000) wide = -64'sh8000_0000;
        hi = int'(wide);
      end
    endcase
  endtask

  // A uniformly drawn sample between two bounds, both included.
  function automatic logic [31:0] pick_between(input int a, input int b);
    longint          lo_l, hi_l;
    longint unsigned span, r;
    lo_l = (a < b) ? a : b;
    hi_l = (a < b) ? b : a;
    span = $unsigned(hi_l - lo_l + 1);
    r = {$urandom, $urandom};
    return 32'(lo_l + longint'(r % span));
  endfunction

  function automatic logic [31:0] pick_sample();
    int k, edge_pick;
    k = $urandom_range(0, 9);
    if (k <= 5) return pick_between(color_low, color_high);
    if (k == 6) return pick_between(alpha_low, alpha_high);
    if (k == 9) return $urandom;
    // Just around one of the four bounds, where the clamps switch.
    case ($urandom_range(0, 3))
      0: edge_pick = color_low;
      1: edge_pick = color_high;
      2: edge_pick = alpha_low;
      default: edge_pick = alpha_high;
    endcase
    return edge_pick + $urandom_range(0, 6) - 3;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: offers queued samples, holding off at random. A new item is
  // put on the bus only when the previous one has been taken or none is up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_colors = {expected_colors, predict_color(s_tdata)};
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= pending_samples.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Color monitor: checks each accepted item against the oldest prediction and
  // stalls the output at random.
  // ---------------------------------------------------------------------------
  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : color_monitor
    rgba_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color, expected none, got %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_colors.pop_front();
          check_channel("red",   want.red,   got.red);
          check_channel("green", want.green, got.green);
          check_channel("blue",  want.blue,  got.blue);
          check_channel("alpha", want.alpha, got.alpha);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int p, i;
    int c_lo, c_hi, a_lo, a_hi;
    int k;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 62;

    // Reset defaults: all bounds are zero, so every sample is white and opaque.
    queue_sample(32'h0000_0000);
    queue_sample(32'h8000_0000);
    queue_sample(32'h7FFF_FFFF);
    wait_until_drained();

    // Ordinary ramp over [-1, 2] with the default green, yellow, red stops and
    // alpha rising over [0, 1]. Covers both ends, the clamps and the middle.
    program_bounds(32'hFFFF_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000);
    queue_sample(32'hFFFF_0000);
    queue_sample(32'h0002_0000);
    queue_sample(32'h0000_0000);
    queue_sample(32'h0000_8000);
    queue_sample(32'h8000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'hFFFF_8000);
    queue_sample(32'h0001_0000);
    wait_until_drained();

    // Equal nonzero bounds on both ramps, and a stop count above the table
    // size that has to saturate to eight stops.
    program_bounds(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFB, 32'hFFFF_FFFB);
    program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd12);
    program_register(pwlcm_pkg::REG_STOPS_LOW,  64'h0123_4567_89AB_CDEF);
    program_register(pwlcm_pkg::REG_STOPS_MID,  64'hFEDC_BA98_7654_3210);
    program_register(pwlcm_pkg::REG_STOPS_HIGH, 64'hA5A5_5A5A_F00F_0FF0);
    queue_sample(32'h0001_0000);
    queue_sample(32'h0001_0001);
    queue_sample(32'h0000_FFFF);
    queue_sample(32'hFFFF_FFFB);
    queue_sample(32'hFFFF_FFFC);
    wait_until_drained();

    // Reversed bounds, the color pair at the extremes of the range, and a single stop.
    program_bounds(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000);
    program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd1);
    queue_sample(32'h0000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0000_8000);
    wait_until_drained();

    // No stops in use: white again although the bounds are set.
    program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd0);
    queue_sample(32'h0000_1234);
    queue_sample(32'h8000_0000);
    wait_until_drained();

    // Two stops over the widest possible window on both ramps.
    program_bounds(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd2);
    queue_sample(32'h0000_0000);
    queue_sample(32'h1234_5678);
    queue_sample(32'hC000_0001);
    wait_until_drained();

    // Random phases, each with a fresh register set. The first third stalls
    // the output hard, the second starves the input, the last runs flat out.
    for (p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 62;
      end else if (p < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick_bound_pair(c_lo, c_hi);
      pick_bound_pair(a_lo, a_hi);
      program_bounds(c_lo, c_hi, a_lo, a_hi);
      k = $urandom_range(0, 9);
      if (k == 0)
        program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd0);
      else if (k == 1)
        program_register(pwlcm_pkg::REG_STOP_COUNT, 64'd1);
      else if (k == 2)
        program_register(pwlcm_pkg::REG_STOP_COUNT, 64'($urandom_range(9, 15)));
      else
        program_register(pwlcm_pkg::REG_STOP_COUNT, 64'($urandom_range(2, STOP_LIMIT)));
      program_register(pwlcm_pkg::REG_STOPS_LOW,  {$urandom, $urandom});
      program_register(pwlcm_pkg::REG_STOPS_MID,  {$urandom, $urandom});
      program_register(pwlcm_pkg::REG_STOPS_HIGH, {$urandom, $urandom});

      for (i = 0; i < ITEMS_PER_PHASE; i++)
        queue_sample(pick_sample());
      wait_until_drained();
    end

    // Leave room for any stray item to show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
